// ===== rtl/core/xmpcu_pkg.sv =====
package xmpcu_pkg;

  // Configuration register indexes.
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT     = 1'b1;

  // Limits of the pattern geometry.
  localparam int MaxChannels = 32;
  localparam int MaxRows     = 256;

  // Widths derived from the fixed field widths.
  localparam int ChanW = 5;
  localparam int RowW  = 8;
  localparam int CellW = 40;

  // Byte decoding.
  localparam int  MaskFlagBit   = 7;
  localparam logic [4:0] NoteFollowMask = 5'b11110;

  // Last valid counter positions, taken from the configuration registers.
  typedef struct packed {
    logic [ChanW-1:0] chan_last;
    logic [RowW-1:0]  row_last;
  } xmpcu_lim_t;

  // One finished cell with its position.
  typedef struct packed {
    logic             last_cell;
    logic [ChanW-1:0] chan_idx;
    logic [RowW-1:0]  row_index;
    logic [CellW-1:0] cell_data;
  } xmpcu_res_t;

endpackage

// ===== rtl/core/xm_pattern_cell_unpacker_unit.sv =====
// Packed pattern cell unpacker. Bytes of packed pattern data enter on the s_ side, one per
// word, with tuser set on the first byte of a pattern; finished cells leave on the m_ side
// with their row and channel, and tlast marks the last cell of the pattern. The block takes
// one byte every cycle: a byte is held in the input register and decoded in one pass into the
// output register, which presents the cell once its final byte is decoded; the input stalls
// only while the output register holds a word that is not taken. The user must write channel
// and row counts through the cfg port only while no byte is in flight; the block does not enforce it.
module xm_pattern_cell_unpacker_unit
  import xmpcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value
  input  logic        s_tuser,   // pat_begin
  output logic        m_tvalid,
  input  logic        m_tready,
  // note, instrument, volume_byte, effect, effect_param, row_index, chan_idx, zero pad
  output logic [55:0] m_tdata,
  output logic        m_tlast,   // last_cell
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       step;
  logic       emit;
  xmpcu_lim_t lim;
  xmpcu_res_t res;
  xmpcu_res_t out_res;

  // The input word moves on when the output register is free or being emptied.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  xmpcu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lim       (lim)
  );

  xmpcu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .byte_value (in_byte),
    .pat_begin  (in_start),
    .lim        (lim),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.chan_idx, out_res.row_index, out_res.cell_data};
  assign m_tlast = out_res.last_cell;

endmodule

// ===== rtl/core/xmpcu_cfg.sv =====
module xmpcu_cfg
  import xmpcu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  output xmpcu_lim_t lim
);

  logic [5:0] channel_count;
  logic [8:0] row_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 6'd1;
      row_count     <= 9'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[5:0];
        REG_ROW_COUNT:     row_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one; counts above the limit saturate.
  always_comb begin
    if (channel_count == 6'd0) begin
      lim.chan_last = '0;
    end else if (channel_count >= 6'(MaxChannels)) begin
      lim.chan_last = ChanW'(MaxChannels - 1);
    end else begin
      lim.chan_last = ChanW'(channel_count - 6'd1);
    end
    if (row_count == 9'd0) begin
      lim.row_last = '0;
    end else if (row_count >= 9'(MaxRows)) begin
      lim.row_last = RowW'(MaxRows - 1);
    end else begin
      lim.row_last = RowW'(row_count - 9'd1);
    end
  end

endmodule

// ===== rtl/core/xmpcu_decode.sv =====
module xmpcu_decode
  import xmpcu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_value,
  input  logic       pat_begin,
  input  xmpcu_lim_t lim,
  output logic       emit,
  output xmpcu_res_t res
);

  logic [4:0]       pending_mask, pending_mask_next;
  logic             cell_open, cell_open_next;
  logic [CellW-1:0] partial_cell, partial_cell_next;
  logic [RowW-1:0]  row_counter, row_counter_next;
  logic [ChanW-1:0] channel_counter, channel_counter_next;
  logic             pattern_done, pattern_done_next;

  logic [4:0]       pm, field_hot, pm_left;
  logic             open_now, done_now;
  logic [CellW-1:0] pc, pc_fill;
  logic [RowW-1:0]  row_now;
  logic [ChanW-1:0] ch_now;
  logic             end_of_row, last_row;

  always_comb begin
    // A pattern start clears everything before the byte is decoded.
    pm       = pat_begin ? '0 : pending_mask;
    open_now = pat_begin ? 1'b0 : cell_open;
    pc       = pat_begin ? '0 : partial_cell;
    row_now  = pat_begin ? '0 : row_counter;
    ch_now   = pat_begin ? '0 : channel_counter;
    done_now = pat_begin ? 1'b0 : pattern_done;

    // The next byte fills the lowest field still pending.
    field_hot = pm & (~pm + 5'd1);
    pm_left   = pm & ~field_hot;
    pc_fill   = pc;
    for (int k = 0; k < 5; k++) begin
      if (field_hot[k]) pc_fill[8*k +: 8] = byte_value;
    end

    pending_mask_next    = pm;
    cell_open_next       = open_now;
    partial_cell_next    = pc;
    row_counter_next     = row_now;
    channel_counter_next = ch_now;
    pattern_done_next    = done_now;
    emit                 = 1'b0;
    res.cell_data        = '0;

    if (!done_now) begin
      if (!open_now) begin
        partial_cell_next = '0;
        if (byte_value[MaskFlagBit]) begin
          pending_mask_next = byte_value[4:0];
          if (byte_value[4:0] == 5'd0) begin
            emit = 1'b1;
          end else begin
            cell_open_next = 1'b1;
          end
        end else begin
          partial_cell_next = CellW'(byte_value);
          pending_mask_next = NoteFollowMask;
          cell_open_next    = 1'b1;
        end
      end else if (pm == 5'd0) begin
        emit          = 1'b1;
        res.cell_data = pc;
      end else begin
        partial_cell_next = pc_fill;
        pending_mask_next = pm_left;
        if (pm_left == 5'd0) begin
          emit          = 1'b1;
          res.cell_data = pc_fill;
        end
      end
    end

    end_of_row    = ch_now >= lim.chan_last;
    last_row      = row_now >= lim.row_last;
    res.row_index = row_now;
    res.chan_idx  = ch_now;
    res.last_cell = end_of_row && last_row;

    if (emit) begin
      if (res.last_cell) begin
        pattern_done_next = 1'b1;
      end else if (end_of_row) begin
        channel_counter_next = '0;
        row_counter_next     = row_now + RowW'(1);
      end else begin
        channel_counter_next = ch_now + ChanW'(1);
      end
      cell_open_next    = 1'b0;
      pending_mask_next = '0;
      partial_cell_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask    <= '0;
      cell_open       <= 1'b0;
      partial_cell    <= '0;
      row_counter     <= '0;
      channel_counter <= '0;
      pattern_done    <= 1'b0;
    end else if (step) begin
      pending_mask    <= pending_mask_next;
      cell_open       <= cell_open_next;
      partial_cell    <= partial_cell_next;
      row_counter     <= row_counter_next;
      channel_counter <= channel_counter_next;
      pattern_done    <= pattern_done_next;
    end
  end

endmodule
